// ===== rtl/tscu_pkg.sv =====
`timescale 1ns / 1ps
package tscu_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int TEMPO_W       = 18;
	localparam int VAL_W         = 32;
	// quotient and divisor widths of the cell chains
	localparam int QW            = 46;
	localparam int DW            = 46;
	// quantizer tree
	localparam int Q_CAND        = 17;
	localparam int Q_LEAVES      = 32;
	localparam int Q_LVL         = 5;
	localparam int QV_W          = 34;

	localparam logic [TEMPO_W-1:0] TEMPO_RESET = 18'd30720;
	localparam logic [23:0] MS_DIV  = 24'd15360000;
	localparam logic [23:0] SEC_DIV = 24'd15360;

	localparam logic [1:0] MODE_TO_BEATS   = 2'd0;
	localparam logic [1:0] MODE_FROM_BEATS = 2'd1;
	localparam logic [1:0] MODE_QUANT      = 2'd2;
	localparam logic [1:0] MODE_NONE       = 2'd3;

	localparam logic [1:0] UNIT_MS  = 2'd0;
	localparam logic [1:0] UNIT_S   = 2'd1;
	localparam logic [1:0] UNIT_HZ  = 2'd2;
	localparam logic [1:0] UNIT_GEN = 2'd3;

	localparam int NOTE_NUM [16] = '{4, 2, 1, 3, 1, 1, 1, 3, 1, 1, 3, 1, 1, 3, 1, 1};
	localparam int NOTE_DEN [16] = '{1, 1, 1, 4, 2, 3, 4, 16, 6, 8, 32, 12, 16, 64, 24, 32};

	typedef struct packed {
		logic              direct;
		logic [VAL_W-1:0]  dres;
		logic              dsat;
		logic              neg;
		logic              two_pass;
		logic              quant;
	} side_t;

	// clamp a sign and magnitude to 32 bits: {sat, value}
	function automatic logic [VAL_W:0] pack(input logic neg, input logic ovf,
			input logic [QW-1:0] mag);
		logic [VAL_W:0] o;
		if (!neg) begin
			if (ovf || mag > QW'(32'h7FFF_FFFF))
				o = {1'b1, 32'h7FFF_FFFF};
			else
				o = {1'b0, mag[VAL_W-1:0]};
		end else begin
			if (ovf || mag > QW'(33'h1_0000_0000 >> 1))
				o = {1'b1, 32'h8000_0000};
			else
				o = {1'b0, 32'(~mag[VAL_W-1:0] + 32'd1)};
		end
		return o;
	endfunction

endpackage

// ===== rtl/tscu_cell.sv =====
`timescale 1ns / 1ps
// One restoring division step: take the next numerator bit, subtract if it fits.
module tscu_cell #(
	parameter int DW = tscu_pkg::DW,
	parameter int QW = tscu_pkg::QW
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_v,
	input  logic [DW-1:0]         in_r,
	input  logic [QW-1:0]         in_x,
	input  logic [QW-1:0]         in_q,
	input  logic [DW-1:0]         in_d,
	input  logic                  in_ovf,
	input  tscu_pkg::side_t       in_side,
	output logic                  out_v,
	output logic [DW-1:0]         out_r,
	output logic [QW-1:0]         out_x,
	output logic [QW-1:0]         out_q,
	output logic [DW-1:0]         out_d,
	output logic                  out_ovf,
	output tscu_pkg::side_t       out_side
);

	logic [DW:0] r2;
	logic [DW:0] rn;
	logic        ge;

	always_comb begin
		r2 = {in_r, in_x[QW-1]};
		ge = r2 >= {1'b0, in_d};
		rn = ge ? (r2 - {1'b0, in_d}) : r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else begin
			out_v <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		out_r    <= rn[DW-1:0];
		out_x    <= {in_x[QW-2:0], 1'b0};
		out_q    <= {in_q[QW-2:0], ge};
		out_d    <= in_d;
		out_ovf  <= in_ovf;
		out_side <= in_side;
	end

endmodule

// ===== rtl/tscu_chain.sv =====
`timescale 1ns / 1ps
// Truncating divider: entry stage checks overflow, then QW cells, one quotient bit each.
module tscu_chain #(
	parameter int DW = tscu_pkg::DW,
	parameter int QW = tscu_pkg::QW,
	parameter int XW = 56
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_v,
	input  logic [XW-1:0]    in_x,
	input  logic [DW-1:0]    in_d,
	input  tscu_pkg::side_t  in_side,
	output logic             out_v,
	output logic [QW-1:0]    out_q,
	output logic             out_ovf,
	output tscu_pkg::side_t  out_side
);

	localparam int RW = XW - QW;
	localparam int CW = (RW > DW) ? RW : DW;

	logic            cv [QW+1];
	logic [DW-1:0]   cr [QW+1];
	logic [QW-1:0]   cx [QW+1];
	logic [QW-1:0]   cq [QW+1];
	logic [DW-1:0]   cd [QW+1];
	logic            co [QW+1];
	tscu_pkg::side_t cs [QW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv[0] <= 1'b0;
		end else begin
			cv[0] <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		cr[0] <= DW'(in_x[XW-1:QW]);
		co[0] <= CW'(in_x[XW-1:QW]) >= CW'(in_d);
		cx[0] <= in_x[QW-1:0];
		cq[0] <= '0;
		cd[0] <= in_d;
		cs[0] <= in_side;
	end

	for (genvar i = 0; i < QW; i++) begin : g_cell
		tscu_cell #(.DW(DW), .QW(QW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_v     (cv[i]),
			.in_r     (cr[i]),
			.in_x     (cx[i]),
			.in_q     (cq[i]),
			.in_d     (cd[i]),
			.in_ovf   (co[i]),
			.in_side  (cs[i]),
			.out_v    (cv[i+1]),
			.out_r    (cr[i+1]),
			.out_x    (cx[i+1]),
			.out_q    (cq[i+1]),
			.out_d    (cd[i+1]),
			.out_ovf  (co[i+1]),
			.out_side (cs[i+1])
		);
	end

	assign out_v    = cv[QW];
	assign out_q    = cq[QW];
	assign out_ovf  = co[QW];
	assign out_side = cs[QW];

endmodule

// ===== rtl/tscu_qmin.sv =====
`timescale 1ns / 1ps
// Registered minimum tree; on equal distance keep the left (earlier) candidate.
module tscu_qmin #(
	parameter int LEAVES = tscu_pkg::Q_LEAVES,
	parameter int VW     = tscu_pkg::QV_W
) (
	input  logic                 clk,
	input  logic signed [VW-1:0] in_val  [LEAVES],
	input  logic [VW-1:0]        in_dist [LEAVES],
	output logic signed [VW-1:0] out_val
);

	logic signed [VW-1:0] nv [1:LEAVES-1];
	logic [VW-1:0]        nd [1:LEAVES-1];

	for (genvar i = 1; i < LEAVES; i++) begin : g_node
		if (2 * i >= LEAVES) begin : g_leaf
			always_ff @(posedge clk) begin
				if (in_dist[2*i-LEAVES] <= in_dist[2*i+1-LEAVES]) begin
					nv[i] <= in_val[2*i-LEAVES];
					nd[i] <= in_dist[2*i-LEAVES];
				end else begin
					nv[i] <= in_val[2*i+1-LEAVES];
					nd[i] <= in_dist[2*i+1-LEAVES];
				end
			end
		end else begin : g_inner
			always_ff @(posedge clk) begin
				if (nd[2*i] <= nd[2*i+1]) begin
					nv[i] <= nv[2*i];
					nd[i] <= nd[2*i];
				end else begin
					nv[i] <= nv[2*i+1];
					nd[i] <= nd[2*i+1];
				end
			end
		end
	end

	assign out_val = nv[1];

endmodule

// ===== rtl/tempo_sync_converter_unit.sv =====
`timescale 1ns / 1ps
// Channel   | Signals                        | Handshake
// ----------+--------------------------------+-----------------------------------
// request   | mode, unit, value              | taken when start high, busy low
// result    | result, saturated              | done high for one cycle, no stall
// config    | cfg_wdata (tempo, 1/256 BPM)   | written when cfg_we high
//
// One request is taken every cycle; busy never rises.
// Each result passes through one prepare stage, five levels of the quantizer
// tree, two 47-stage divider cell chains and one stage between and after them.
// Most of the stages lie in the cell chains.
// Reset clears the valid bits of the pipeline and loads the tempo with 120 BPM.
// The receiver cannot stall; results leave in request order.
module tempo_sync_converter_unit #(
	parameter int FRAC_BITS = tscu_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    mode,
	input  logic [1:0]                    unit,
	input  logic signed [31:0]            value,
	input  logic                          cfg_we,
	input  logic [tscu_pkg::TEMPO_W-1:0]  cfg_wdata,
	output logic                          done,
	output logic signed [31:0]            result,
	output logic                          saturated
);

	localparam int QW  = tscu_pkg::QW;
	localparam int DW  = tscu_pkg::DW;
	localparam int TW  = tscu_pkg::TEMPO_W;
	localparam int VW  = tscu_pkg::QV_W;
	localparam int NL  = tscu_pkg::Q_LEAVES;
	localparam int NC  = tscu_pkg::Q_CAND;
	localparam int LV  = tscu_pkg::Q_LVL;
	// numerator: largest of m*15360000 and tempo << 2F
	localparam int NW  = (TW + 2 * FRAC_BITS > 55) ? TW + 2 * FRAC_BITS : 55;
	localparam int XW  = NW + 1;
	localparam int GS  = FRAC_BITS - 4;
	localparam int LAT = 3 + LV + 2 * (QW + 1);

	// tempo register
	logic [TW-1:0] tempo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tempo_q <= tscu_pkg::TEMPO_RESET;
		end else if (cfg_we) begin
			tempo_q <= cfg_wdata;
		end
	end

	// the whole pipeline advances every cycle
	assign busy = 1'b0;

	// note table, rounded to the fixed-point format
	logic signed [VW-1:0] note_val [16];
	for (genvar i = 0; i < 16; i++) begin : g_note
		localparam longint NUMV = tscu_pkg::NOTE_NUM[i];
		localparam longint DENV = tscu_pkg::NOTE_DEN[i];
		localparam longint CV   = ((NUMV << (FRAC_BITS + 1)) + DENV) / (2 * DENV);
		assign note_val[i] = VW'(CV);
	end

	// ---------------- prepare stage ----------------
	logic                 neg_c;
	logic [31:0]          mag_c;
	logic [23:0]          mul_b;
	logic [55:0]          prod;
	logic [NW-1:0]        n_c;
	logic [DW-1:0]        d_c;
	tscu_pkg::side_t      side_c;
	logic [32:0]          gsum;
	logic [32:0]          gm;
	logic signed [VW-1:0] gval_c;
	logic signed [VW-1:0] v_c;
	logic [VW-1:0]        dist_c [NC];
	logic                 pass_c;

	function automatic logic [VW-1:0] absdiff(input logic signed [VW-1:0] a,
			input logic signed [VW-1:0] b);
		logic signed [VW-1:0] d;
		d = a - b;
		return d[VW-1] ? VW'(-d) : VW'(d);
	endfunction

	always_comb begin
		neg_c = value[31];
		mag_c = neg_c ? (~value + 32'd1) : value;
		v_c   = {{(VW-32){value[31]}}, value};

		// one multiplier; pick the constant or the tempo as its second operand
		if (mode == tscu_pkg::MODE_TO_BEATS && unit != tscu_pkg::UNIT_HZ)
			mul_b = 24'(tempo_q);
		else if (unit == tscu_pkg::UNIT_MS)
			mul_b = tscu_pkg::MS_DIV;
		else
			mul_b = tscu_pkg::SEC_DIV;
		prod = 56'(mag_c) * 56'(mul_b);

		pass_c = mode == tscu_pkg::MODE_NONE || tempo_q == '0 ||
			unit == tscu_pkg::UNIT_GEN;

		side_c          = '0;
		side_c.neg      = neg_c;
		side_c.quant    = mode == tscu_pkg::MODE_QUANT;
		side_c.two_pass = mode == tscu_pkg::MODE_FROM_BEATS && unit == tscu_pkg::UNIT_HZ;
		n_c             = NW'(prod);
		d_c             = DW'(tempo_q);

		if (mode == tscu_pkg::MODE_TO_BEATS) begin
			if (unit == tscu_pkg::UNIT_HZ) begin
				n_c = NW'(tempo_q) << (2 * FRAC_BITS);
				d_c = DW'(prod);
			end else begin
				d_c = DW'((unit == tscu_pkg::UNIT_MS) ? tscu_pkg::MS_DIV : tscu_pkg::SEC_DIV);
			end
		end

		if (!side_c.quant) begin
			if (pass_c) begin
				side_c.direct   = 1'b1;
				side_c.dres     = value;
				side_c.two_pass = 1'b0;
			end else if (mode == tscu_pkg::MODE_TO_BEATS && unit == tscu_pkg::UNIT_HZ &&
					(neg_c || mag_c == '0)) begin
				// rate not positive: result zero
				side_c.direct = 1'b1;
			end
		end

		// nearest 1/16 grid point, ties away from zero
		gsum   = {1'b0, mag_c} + (33'd1 << (GS - 1));
		gm     = (gsum >> GS) << GS;
		gval_c = neg_c ? VW'(-$signed({1'b0, gm})) : VW'({1'b0, gm});

		dist_c[0] = absdiff(v_c, gval_c);
		for (int i = 0; i < 16; i++)
			dist_c[i+1] = absdiff(v_c, note_val[i]);
	end

	logic                 v_s1;
	tscu_pkg::side_t      side_s1;
	logic [NW-1:0]        n_s1;
	logic [DW-1:0]        d_s1;
	logic signed [VW-1:0] gval_s1;
	logic [VW-1:0]        dist_s1 [NC];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		side_s1 <= side_c;
		n_s1    <= n_c;
		d_s1    <= d_c;
		gval_s1 <= gval_c;
		dist_s1 <= dist_c;
	end

	// ---------------- quantizer tree, with the divider operands held alongside ----
	logic signed [VW-1:0] leaf_val  [NL];
	logic [VW-1:0]        leaf_dist [NL];
	logic signed [VW-1:0] best;

	always_comb begin
		for (int j = 0; j < NL; j++) begin
			leaf_val[j]  = '0;
			leaf_dist[j] = '1;
		end
		leaf_val[0]  = gval_s1;
		leaf_dist[0] = dist_s1[0];
		for (int j = 1; j < NC; j++) begin
			leaf_val[j]  = note_val[j-1];
			leaf_dist[j] = dist_s1[j];
		end
	end

	tscu_qmin #(.LEAVES(NL), .VW(VW)) u_qmin (
		.clk     (clk),
		.in_val  (leaf_val),
		.in_dist (leaf_dist),
		.out_val (best)
	);

	logic            dly_v_q    [LV];
	logic [XW-1:0]   dly_x_q    [LV];
	logic [DW-1:0]   dly_d_q    [LV];
	tscu_pkg::side_t dly_side_q [LV];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LV; k++)
				dly_v_q[k] <= 1'b0;
		end else begin
			dly_v_q[0] <= v_s1;
			for (int k = 1; k < LV; k++)
				dly_v_q[k] <= dly_v_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		// add half the divisor so the floor division rounds to nearest
		dly_x_q[0]    <= XW'(n_s1) + XW'(d_s1 >> 1);
		dly_d_q[0]    <= d_s1;
		dly_side_q[0] <= side_s1;
		for (int k = 1; k < LV; k++) begin
			dly_x_q[k]    <= dly_x_q[k-1];
			dly_d_q[k]    <= dly_d_q[k-1];
			dly_side_q[k] <= dly_side_q[k-1];
		end
	end

	tscu_pkg::side_t      side_a_in;
	logic [32:0]          qpack;
	logic                 best_neg;

	always_comb begin
		best_neg  = best[VW-1];
		qpack     = tscu_pkg::pack(best_neg, 1'b0,
			best_neg ? QW'(VW'(-best)) : QW'(VW'(best)));
		side_a_in = dly_side_q[LV-1];
		if (side_a_in.quant) begin
			side_a_in.direct = 1'b1;
			side_a_in.dres   = qpack[31:0];
			side_a_in.dsat   = qpack[32];
		end
	end

	// ---------------- first division ----------------
	logic            a_v;
	logic [QW-1:0]   a_q;
	logic            a_ovf;
	tscu_pkg::side_t a_side;

	tscu_chain #(.DW(DW), .QW(QW), .XW(XW)) u_chain_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_v     (dly_v_q[LV-1]),
		.in_x     (dly_x_q[LV-1]),
		.in_d     (dly_d_q[LV-1]),
		.in_side  (side_a_in),
		.out_v    (a_v),
		.out_q    (a_q),
		.out_ovf  (a_ovf),
		.out_side (a_side)
	);

	// ---------------- between the chains: settle results or form the rate division ----
	logic [QW-1:0]   per_c;
	logic [32:0]     apack;
	tscu_pkg::side_t side_m;

	always_comb begin
		// a negative or zero period is raised to one least step
		per_c  = (a_side.neg || a_q == '0) ? QW'(1) : a_q;
		apack  = tscu_pkg::pack(a_side.neg, a_ovf, a_q);
		side_m = a_side;
		if (!a_side.direct && !a_side.two_pass) begin
			side_m.direct = 1'b1;
			side_m.dres   = apack[31:0];
			side_m.dsat   = apack[32];
		end
	end

	logic            mid_v_q;
	logic [XW-1:0]   mid_x_q;
	logic [DW-1:0]   mid_d_q;
	tscu_pkg::side_t mid_side_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_v_q <= 1'b0;
		end else begin
			mid_v_q <= a_v;
		end
	end

	always_ff @(posedge clk) begin
		mid_x_q    <= (XW'(1) << (2 * FRAC_BITS)) + XW'(per_c >> 1);
		mid_d_q    <= DW'(per_c);
		mid_side_q <= side_m;
	end

	// ---------------- second division ----------------
	logic            b_v;
	logic [QW-1:0]   b_q;
	logic            b_ovf;
	tscu_pkg::side_t b_side;
	logic [32:0]     bpack;

	tscu_chain #(.DW(DW), .QW(QW), .XW(XW)) u_chain_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_v     (mid_v_q),
		.in_x     (mid_x_q),
		.in_d     (mid_d_q),
		.in_side  (mid_side_q),
		.out_v    (b_v),
		.out_q    (b_q),
		.out_ovf  (b_ovf),
		.out_side (b_side)
	);

	assign bpack = tscu_pkg::pack(1'b0, b_ovf, b_q);

	// ---------------- output register ----------------
	logic        done_q;
	logic [31:0] result_q;
	logic        sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= b_v;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= b_side.direct ? b_side.dres : bpack[31:0];
		sat_q    <= b_side.direct ? b_side.dsat : bpack[32];
	end

	assign done      = done_q;
	assign result    = result_q;
	assign saturated = sat_q;

	// ---------------- assertions ----------------
	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("request did not produce a result at the fixed latency");

	a_sat_value : assert property (@(posedge clk) disable iff (!arst_n)
		done && saturated |-> result == 32'h7FFF_FFFF || result == 32'h8000_0000)
		else $error("saturated result is not a range limit");

	a_tempo_write : assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> tempo_q == $past(cfg_wdata))
		else $error("tempo write lost");

endmodule

// ===== verif/tempo_sync_converter_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the tempo sync converter.
// The driver takes requests, tempo writes and drain markers from one queue,
// in order. A predictor written in exact integer arithmetic works out the
// result of every accepted request. The monitor checks each done strobe
// against the oldest prediction still waiting.
module tempo_sync_converter_unit_tb;

	localparam int LATENCY   = 102;
	localparam int SETTLE    = LATENCY + 10;
	localparam int CYCLE_CAP = 200000;

	typedef enum logic [1:0] {OP_REQ, OP_TEMPO, OP_DRAIN} op_kind_t;

	typedef struct {
		op_kind_t                     kind;
		logic [1:0]                   mode;
		logic [1:0]                   unit;
		logic [31:0]                  value;
		logic [tscu_pkg::TEMPO_W-1:0] tempo;
		bit                           steady;  // no idle bursts for this one
	} op_t;

	typedef struct {
		logic [31:0] result;
		logic        saturated;
	} conv_t;

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic [1:0]                   mode;
	logic [1:0]                   unit;
	logic signed [31:0]           value;
	logic                         cfg_we;
	logic [tscu_pkg::TEMPO_W-1:0] cfg_wdata;
	logic                         done;
	logic signed [31:0]           result;
	logic                         saturated;

	op_t   pending_ops[$];
	conv_t expected_conv[$];
	logic [tscu_pkg::TEMPO_W-1:0] tempo_shadow;
	int    error_count = 0;
	int    cycle_count = 0;

	tempo_sync_converter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.mode      (mode),
		.unit      (unit),
		.value     (value),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.result    (result),
		.saturated (saturated)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// round(a*b*2^sh / den), ties up; saturate when the quotient needs more than 64 bits
	function automatic logic [63:0] round_div(input logic [63:0] a, input logic [63:0] b,
			input int sh, input logic [63:0] den);
		logic [127:0] num;
		logic [127:0] q;
		if (den == 0)
			return '1;
		num = ((128'(a) * 128'(b)) << sh) + 128'(den >> 1);
		q = num / 128'(den);
		if (q[127:64] != 0)
			return '1;
		return q[63:0];
	endfunction

	function automatic conv_t clamp32(input bit neg, input logic [63:0] mag);
		conv_t c;
		c.saturated = 1'b0;
		if (!neg) begin
			if (mag > 64'h7FFF_FFFF) begin
				mag = 64'h7FFF_FFFF;
				c.saturated = 1'b1;
			end
			c.result = mag[31:0];
		end else begin
			if (mag > 64'h8000_0000) begin
				mag = 64'h8000_0000;
				c.saturated = 1'b1;
			end
			c.result = 32'(0 - mag[31:0]);
		end
		return c;
	endfunction

	// snap to the 1/16 grid or the nearest note length; earlier candidate wins ties
	function automatic conv_t snap_beats(input bit neg, input logic [63:0] m,
			input longint v);
		logic [63:0] gm;
		longint best, c, d;
		logic [63:0] bd, ed;
		gm = ((m + 64'd2048) >> 12) << 12;
		best = neg ? -longint'(gm) : longint'(gm);
		d = v - best;
		bd = d < 0 ? -d : d;
		for (int i = 0; i < 16; i++) begin
			c = ((longint'(tscu_pkg::NOTE_NUM[i]) << 17) + tscu_pkg::NOTE_DEN[i]) /
				(2 * tscu_pkg::NOTE_DEN[i]);
			d = v - c;
			ed = d < 0 ? -d : d;
			if (ed < bd) begin
				bd = ed;
				best = c;
			end
		end
		return best < 0 ? clamp32(1'b1, 64'(-best)) : clamp32(1'b0, 64'(best));
	endfunction

	function automatic conv_t convert_tempo(input logic [1:0] md, input logic [1:0] un,
			input logic [31:0] raw, input logic [tscu_pkg::TEMPO_W-1:0] tempo);
		bit neg;
		logic [63:0] m, t, p;
		longint v;
		conv_t c;
		neg = raw[31];
		m = neg ? (64'h1_0000_0000 - 64'(raw)) : 64'(raw);
		v = neg ? -longint'(m) : longint'(m);
		t = 64'(tempo);
		if (md == tscu_pkg::MODE_QUANT)
			return snap_beats(neg, m, v);
		if (md == tscu_pkg::MODE_NONE || t == 0 || un == tscu_pkg::UNIT_GEN) begin
			c.result = raw;
			c.saturated = 1'b0;
			return c;
		end
		if (md == tscu_pkg::MODE_TO_BEATS) begin
			case (un)
				tscu_pkg::UNIT_MS:
					return clamp32(neg, round_div(m, t, 0, 64'(tscu_pkg::MS_DIV)));
				tscu_pkg::UNIT_S:
					return clamp32(neg, round_div(m, t, 0, 64'(tscu_pkg::SEC_DIV)));
				default: begin
					if (neg || m == 0)
						return clamp32(1'b0, 64'd0);
					return clamp32(1'b0,
						round_div(t, 64'd1, 32, 64'(tscu_pkg::SEC_DIV) * m));
				end
			endcase
		end
		case (un)
			tscu_pkg::UNIT_MS:
				return clamp32(neg, round_div(m, 64'(tscu_pkg::MS_DIV), 0, t));
			tscu_pkg::UNIT_S:
				return clamp32(neg, round_div(m, 64'(tscu_pkg::SEC_DIV), 0, t));
			default: begin
				// hertz: period first, raised to one least step when tiny
				p = neg ? 64'd0 : round_div(m, 64'(tscu_pkg::SEC_DIV), 0, t);
				if (p == 0)
					p = 64'd1;
				return clamp32(1'b0, round_div(64'd1, 64'd1, 32, p));
			end
		endcase
	endfunction

	// Driver: take the next op from the queue and present it
	int idle_left;
	int settle_left;
	always @(posedge clk or negedge arst_n) begin
		op_t         op;
		logic        nx_start, nx_we;
		logic [1:0]  nx_mode, nx_unit;
		logic [31:0] nx_value;
		logic [tscu_pkg::TEMPO_W-1:0] nx_wdata;
		if (!arst_n) begin
			start        <= 1'b0;
			mode         <= tscu_pkg::MODE_TO_BEATS;
			unit         <= tscu_pkg::UNIT_MS;
			value        <= '0;
			cfg_we       <= 1'b0;
			cfg_wdata    <= tscu_pkg::TEMPO_RESET;
			tempo_shadow <= tscu_pkg::TEMPO_RESET;
			idle_left    = 0;
			settle_left  = SETTLE;
		end else begin
			nx_start = 1'b0;
			nx_we    = 1'b0;
			nx_mode  = mode;
			nx_unit  = unit;
			nx_value = value;
			nx_wdata = cfg_wdata;
			if (start && !busy)
				expected_conv.push_back(convert_tempo(mode, unit, value, tempo_shadow));
			if (start && busy) begin
				// hold the request until it is taken
				nx_start = 1'b1;
			end else if (idle_left > 0) begin
				idle_left--;
			end else if (pending_ops.size() > 0) begin
				op = pending_ops[0];
				if (op.kind == OP_REQ) begin
					if (!op.steady && $urandom_range(0, 9) == 0) begin
						idle_left = $urandom_range(1, 7) - 1;
					end else begin
						void'(pending_ops.pop_front());
						nx_start = 1'b1;
						nx_mode  = op.mode;
						nx_unit  = op.unit;
						nx_value = op.value;
					end
				end else if (expected_conv.size() == 0 && !(start && !busy)) begin
					// pipeline empty: let it settle, then write or move on
					if (settle_left > 0) begin
						settle_left--;
					end else begin
						void'(pending_ops.pop_front());
						settle_left = SETTLE;
						if (op.kind == OP_TEMPO) begin
							nx_we        = 1'b1;
							nx_wdata     = op.tempo;
							tempo_shadow <= op.tempo;
						end
					end
				end
			end
			start     <= nx_start;
			mode      <= nx_mode;
			unit      <= nx_unit;
			value     <= nx_value;
			cfg_we    <= nx_we;
			cfg_wdata <= nx_wdata;
		end
	end

	// Monitor: check every strobe against the oldest prediction
	always @(posedge clk) begin
		conv_t exp_c;
		if (arst_n && done) begin
			if (expected_conv.size() == 0) begin
				$display("%0t: unexpected result %h sat %b", $time, result, saturated);
				error_count++;
			end else begin
				exp_c = expected_conv.pop_front();
				if (result !== exp_c.result) begin
					$display("%0t: result expected %h actual %h", $time, exp_c.result,
						result);
					error_count++;
				end
				if (saturated !== exp_c.saturated) begin
					$display("%0t: saturated expected %b actual %b", $time,
						exp_c.saturated, saturated);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("tempo_sync_converter_unit verification failed");
			$finish;
		end
	end

	function automatic op_t make_req(input logic [1:0] md, input logic [1:0] un,
			input logic [31:0] val, input bit steady);
		op_t op;
		op.kind   = OP_REQ;
		op.mode   = md;
		op.unit   = un;
		op.value  = val;
		op.tempo  = '0;
		op.steady = steady;
		return op;
	endfunction

	function automatic op_t make_ctl(input op_kind_t kind,
			input logic [tscu_pkg::TEMPO_W-1:0] tempo);
		op_t op;
		op = make_req(tscu_pkg::MODE_TO_BEATS, tscu_pkg::UNIT_MS, '0, 1'b0);
		op.kind  = kind;
		op.tempo = tempo;
		return op;
	endfunction

	// Random value: mostly plausible magnitudes, some full range, some near notes
	function automatic logic [31:0] pick_value(input logic [1:0] md);
		int sel;
		int k;
		logic [31:0] v;
		sel = $urandom_range(0, 9);
		if (sel < 3)
			v = $urandom;
		else if (sel < 6)
			v = $urandom_range(0, 32'h00FF_FFFF);
		else if (sel < 8)
			v = $urandom_range(0, 32'h0004_0000);
		else if (md == tscu_pkg::MODE_QUANT) begin
			k = $urandom_range(0, 15);
			v = ((tscu_pkg::NOTE_NUM[k] << 17) + tscu_pkg::NOTE_DEN[k]) /
				(2 * tscu_pkg::NOTE_DEN[k]);
			v = v + $urandom_range(0, 4096) - 2048;
		end else
			v = $urandom_range(0, 64);
		if ($urandom_range(0, 3) == 0)
			v = -v;
		return v;
	endfunction

	initial begin
		logic [31:0] edge_vals[5];
		logic [tscu_pkg::TEMPO_W-1:0] tempos[6];
		logic [1:0] md;
		int per_phase;
		arst_n = 1'b0;

		// directed: extremes of the value against every unit in to-beats mode, and a few other modes
		edge_vals = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
		foreach (edge_vals[i])
			for (int u = 0; u < 4; u++)
				pending_ops.push_back(make_req(tscu_pkg::MODE_TO_BEATS, u[1:0],
					edge_vals[i], 1'b0));
		pending_ops.push_back(make_req(tscu_pkg::MODE_FROM_BEATS, tscu_pkg::UNIT_HZ,
			32'h0, 1'b0));
		pending_ops.push_back(make_req(tscu_pkg::MODE_FROM_BEATS, tscu_pkg::UNIT_HZ,
			32'h8000_0000, 1'b0));
		pending_ops.push_back(make_req(tscu_pkg::MODE_QUANT, tscu_pkg::UNIT_GEN,
			32'h7FFF_FFFF, 1'b0));
		pending_ops.push_back(make_req(tscu_pkg::MODE_QUANT, tscu_pkg::UNIT_MS,
			32'h0000_1000, 1'b0));
		pending_ops.push_back(make_req(tscu_pkg::MODE_NONE, tscu_pkg::UNIT_S,
			32'h8000_0000, 1'b0));

		// tempo phases: reset value, zero, one step, the top, random, back to 120 BPM
		tempos = '{tscu_pkg::TEMPO_RESET, 18'd0, 18'd1, 18'h3FFFF, 18'($urandom),
			tscu_pkg::TEMPO_RESET};
		per_phase = 180;
		foreach (tempos[ph]) begin
			if (ph > 0)
				pending_ops.push_back(make_ctl(OP_TEMPO, tempos[ph]));
			for (int i = 0; i < per_phase; i++) begin
				md = ($urandom_range(0, 19) == 0) ? tscu_pkg::MODE_NONE :
					2'($urandom_range(0, 2));
				pending_ops.push_back(make_req(md, 2'($urandom_range(0, 3)),
					pick_value(md), ph == 5 && i >= per_phase - 80));
				// hold off until the pipeline empties, once mid phase
				if (ph == 2 && i == per_phase / 2)
					pending_ops.push_back(make_ctl(OP_DRAIN, '0));
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_ops.size() == 0 && expected_conv.size() == 0);
		repeat (SETTLE) @(posedge clk);
		if (error_count == 0 && expected_conv.size() == 0)
			$display("tempo_sync_converter_unit verification clean");
		else
			$display("tempo_sync_converter_unit verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/tscu_pkg.sv
rtl/tscu_cell.sv
rtl/tscu_chain.sv
rtl/tscu_qmin.sv
rtl/tempo_sync_converter_unit.sv
verif/tempo_sync_converter_unit_tb.sv
